>>> sv/sitd_pkg.sv
`timescale 1ns / 1ps

package sitd_pkg;

  localparam int unsigned DIGIT_W = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

  typedef struct packed {
    logic start;
    logic shift;
  } sitd_ctl_t;

  typedef struct packed {
    logic               busy;
    logic [DIGIT_W-1:0] digit;
  } sitd_sts_t;

  function automatic logic [DIGIT_W-1:0] dabble_adj(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
    return r;
  endfunction

endpackage

>>> sv/sitd_if.sv
`timescale 1ns / 1ps

interface sitd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> sv/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Signed integer to decimal ASCII text.
// in_ch (valid/ready/value): one signed integer per transfer; the low
//   VALUE_BITS bits are read as two's complement.
// out_ch (valid/ready/char_code/last): the decimal text, one character per
//   transfer, most significant first, '-' first for negative values, no
//   leading zeros, last set on the final character.
// Steps: load, bit-serial double dabble (one magnitude bit shifted into the
//   BCD register per cycle), hand over, then one character or skipped leading
//   zero per cycle, characters only while the receiver does not stall.
// in_ch.ready is high only while no item is in work; the next item is taken
//   once the final character sits in the output register.
// A receiver stall holds the output register and pauses character emission;
//   the conversion itself runs on.
// Reset (synchronous, active low) drops all work in flight and empties the
//   output register. No clearing pass is needed.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  sitd_in_if.sink    in_ch,
  sitd_out_if.source out_ch
);
  import sitd_pkg::*;

  localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned DCNT_W = $clog2(DIGITS);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DIGITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                state_r;
  logic                  sign_pend_r;
  logic                  lead_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic                  out_valid_r;
  logic [7:0]            out_char_r;
  logic                  out_last_r;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  logic                  in_xfer;
  logic                  can_load;
  logic                  out_load;
  logic                  is_last;
  logic                  skip;
  sitd_ctl_t             ctl;
  sitd_sts_t             sts;

  generate
    if (VALUE_BITS <= 32) begin : g_narrow
      assign raw = in_ch.value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign raw = {{(VALUE_BITS - 32){1'b0}}, in_ch.value};
    end
  endgenerate

  assign negative = raw[VALUE_BITS-1];
  assign mag      = negative ? (~raw + 1'b1) : raw;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign can_load    = !out_valid_r || out_ch.ready;
  assign is_last     = (dcnt_r == DCNT_LAST);
  assign skip        = lead_r && (sts.digit == '0) && !is_last;
  assign out_load    = (state_r == ST_EMIT) && can_load && (sign_pend_r || !skip);

  always_comb begin
    ctl.start = in_xfer;
    ctl.shift = (state_r == ST_EMIT) && !sign_pend_r && (skip || can_load);
  end

  sitd_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .mag   (mag),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sign_pend_r <= 1'b0;
      lead_r      <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sign_pend_r <= negative;
            lead_r      <= 1'b1;
            dcnt_r      <= '0;
            state_r     <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (!sts.busy) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (sign_pend_r) begin
            if (can_load) begin
              out_valid_r <= 1'b1;
              out_char_r  <= CHAR_MINUS;
              out_last_r  <= 1'b0;
              sign_pend_r <= 1'b0;
            end
          end else if (skip) begin
            dcnt_r <= dcnt_r + 1'b1;
          end else if (can_load) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_ZERO + {4'd0, sts.digit};
            out_last_r  <= is_last;
            lead_r      <= 1'b0;
            dcnt_r      <= dcnt_r + 1'b1;
            if (is_last) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = out_char_r;
  assign out_ch.last      = out_last_r;

  a_emit_after_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !sts.busy)
    else $error("emission started while conversion still running");

  a_last_digit_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !sign_pend_r && is_last && can_load)
      |=> (out_valid_r && out_last_r && state_r == ST_IDLE))
    else $error("final digit not flagged as last");

  a_sign_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    sign_pend_r |-> (state_r != ST_IDLE))
    else $error("pending minus sign with no item in work");

  a_no_skip_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && is_last) |-> !skip)
    else $error("final digit position skipped");

endmodule

>>> sv/sitd_dabble.sv
`timescale 1ns / 1ps

module sitd_dabble #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned DIGITS     = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sitd_pkg::sitd_ctl_t   ctl,
  input  logic [VALUE_BITS-1:0] mag,
  output sitd_pkg::sitd_sts_t   sts
);
  import sitd_pkg::*;

  localparam int unsigned BCD_W  = DIGITS * DIGIT_W;
  localparam int unsigned BCNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0] mag_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      bcd_adj;
  logic [BCNT_W-1:0]     bcnt_r;
  logic                  busy_r;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = dabble_adj(bcd_r[i*DIGIT_W +: DIGIT_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      bcnt_r <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      bcnt_r <= '0;
      mag_r  <= mag;
      bcd_r  <= '0;
    end else if (busy_r) begin
      bcd_r  <= {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_r  <= mag_r << 1;
      bcnt_r <= bcnt_r + 1'b1;
      if (bcnt_r == BCNT_LAST) begin
        busy_r <= 1'b0;
      end
    end else if (ctl.shift) begin
      bcd_r <= bcd_r << DIGIT_W;
    end
  end

  assign sts.busy  = busy_r;
  assign sts.digit = bcd_r[BCD_W-1 -: DIGIT_W];

endmodule
